// ===== design/key_click_autorepeat_defines.svh =====
// Assertion macros for the keyboard scan block
`ifndef KEY_CLICK_AUTOREPEAT_DEFINES_SVH
`define KEY_CLICK_AUTOREPEAT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define KCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define KCA_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/kca_pkg.sv =====
`timescale 1ns / 1ps
package kca_pkg;

  localparam int TABLE_SIZE  = 15;
  localparam int GROUPS      = 3;
  localparam int SCAN_W      = 32;
  localparam int KEY_W       = 4;
  localparam int DELAY_W     = 16;
  localparam int CFG_INDEX_W = 4;

  localparam int                 DEF_KEY_COUNT    = 15;
  localparam logic [DELAY_W-1:0] DEF_FIRST_DELAY  = 16'd500;
  localparam logic [DELAY_W-1:0] DEF_REPEAT_DELAY = 16'd175;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DELAY  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY = 4'd1;

  localparam logic [1:0] KEY_GROUP [TABLE_SIZE] = '{
    2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
  };

  localparam logic [SCAN_W-1:0] KEY_MASK [TABLE_SIZE] = '{
    32'h8000_0000, 32'h8000_0000, 32'h4000_0000, 32'h3000_0000, 32'h2000_0000,
    32'h1000_0000, 32'h0800_0000, 32'h0080_0000, 32'h0000_0001, 32'h0000_2000,
    32'h0000_1000, 32'h0000_0080, 32'h0000_0040, 32'h0000_0008, 32'h0000_0001
  };

  typedef logic [GROUPS-1:0][SCAN_W-1:0] scan_words_t;

  typedef struct packed {
    logic [SCAN_W-1:0] scan_group0;
    logic [SCAN_W-1:0] scan_group1;
    logic [SCAN_W-1:0] scan_group2;
    logic [SCAN_W-1:0] now_ms;
    logic              clear_repeat;
  } scan_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] pressed_key;
    logic [KEY_W-1:0] clicked_key;
    logic [KEY_W-1:0] auto_key;
    logic             auto_is_repeat;
  } result_item_t;

  typedef struct packed {
    logic [TABLE_SIZE-1:0] down;
    logic [KEY_W-1:0]      pressed;
    logic [KEY_W-1:0]      clicked;
  } kca_keys_t;

  // every mask bit of the entry reads zero in its group word
  function automatic logic entry_down(scan_words_t words, int pos);
    logic [SCAN_W-1:0] w;
    w = words[KEY_GROUP[pos]];
    return (w & KEY_MASK[pos]) == '0;
  endfunction

endpackage

// ===== design/kca_decode.sv =====
`timescale 1ns / 1ps
module kca_decode import kca_pkg::*; #(
  parameter int KEY_COUNT = DEF_KEY_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  input  scan_item_t item,
  input  logic       update,
  output kca_keys_t  keys
);

  scan_words_t           previous_scan;
  scan_words_t           words;
  logic [TABLE_SIZE-1:0] prev_down;

  assign words = {item.scan_group2, item.scan_group1, item.scan_group0};

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_scan <= '1;
    end else if (update) begin
      previous_scan <= words;
    end
  end

  always_comb begin
    keys = '0;
    prev_down = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      keys.down[i] = entry_down(words, i);
      prev_down[i] = entry_down(previous_scan, i);
    end
    // walk from the top so the lowest table position wins
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (keys.down[i]) begin
        keys.pressed = KEY_W'(i + 1);
      end
      if (keys.down[i] && !prev_down[i]) begin
        keys.clicked = KEY_W'(i + 1);
      end
    end
  end

endmodule

// ===== design/kca_typematic.sv =====
`timescale 1ns / 1ps
module kca_typematic import kca_pkg::*; #(
  parameter int                 KEY_COUNT          = DEF_KEY_COUNT,
  parameter logic [DELAY_W-1:0] FIRST_DELAY_RESET  = DEF_FIRST_DELAY,
  parameter logic [DELAY_W-1:0] REPEAT_DELAY_RESET = DEF_REPEAT_DELAY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]     cfg_data,
  input  scan_item_t             item,
  input  kca_keys_t              keys,
  input  logic                   update,
  output result_item_t           res
);

  logic [DELAY_W-1:0] first_delay_ms;
  logic [DELAY_W-1:0] repeat_delay_ms;
  logic [KEY_W-1:0]   held_key;
  logic [SCAN_W-1:0]  last_event_time;
  logic               repeating;

  logic [KEY_W-1:0]   held_key_next;
  logic [SCAN_W-1:0]  last_event_time_next;
  logic               repeating_next;

  logic [KEY_W-1:0]   held_eff;
  logic               held_down;
  logic [SCAN_W-1:0]  diff;
  logic [DELAY_W-1:0] limit;
  logic               fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay_ms  <= FIRST_DELAY_RESET;
      repeat_delay_ms <= REPEAT_DELAY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIRST_DELAY:  first_delay_ms  <= cfg_data;
        REG_REPEAT_DELAY: repeat_delay_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_eff = item.clear_repeat ? '0 : held_key;
    held_down = 1'b0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (held_eff == KEY_W'(i + 1) && keys.down[i]) begin
        held_down = 1'b1;
      end
    end
    diff  = item.now_ms - last_event_time;
    limit = repeating ? repeat_delay_ms : first_delay_ms;
    // signed wrap: a negative difference never fires
    fire  = !diff[SCAN_W-1] && (diff > {{(SCAN_W-DELAY_W){1'b0}}, limit});

    held_key_next        = held_eff;
    last_event_time_next = last_event_time;
    repeating_next       = repeating;
    res                  = '0;
    res.pressed_key      = keys.pressed;
    res.clicked_key      = keys.clicked;

    if (keys.clicked != '0) begin
      held_key_next        = keys.clicked;
      repeating_next       = 1'b0;
      last_event_time_next = item.now_ms;
      res.auto_key         = keys.clicked;
    end else if (held_down) begin
      if (fire) begin
        repeating_next       = 1'b1;
        last_event_time_next = item.now_ms;
        res.auto_key         = held_eff;
        res.auto_is_repeat   = 1'b1;
      end
    end else begin
      held_key_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_key        <= '0;
      last_event_time <= '0;
      repeating       <= 1'b0;
    end else if (update) begin
      held_key        <= held_key_next;
      last_event_time <= last_event_time_next;
      repeating       <= repeating_next;
    end
  end

endmodule

// ===== design/key_click_autorepeat.sv =====
`timescale 1ns / 1ps
// Keyboard scan decoder with click detection and typematic autorepeat.
// scan channel: one item per keyboard scan (three active-low group words,
//   millisecond time, clear_repeat). Taken when scan_valid is high and
//   scan_stall is low.
// result channel: one item per scan (pressed, clicked, auto key and repeat
//   flag). Taken when result_valid is high and result_stall is low.
// cfg channel: cfg_index 0 writes first_delay_ms, 1 writes repeat_delay_ms,
//   others are ignored; cfg_ready is always high. Write only while idle.
// A taken item waits in the input register and moves to the result register
//   once the result side is free, so a stalled result holds it there.
//   Throughput is one item per cycle unless the result stalls, set by the
//   single pass of table match plus the 32-bit elapsed-time compare.
// Reset clears both pipeline registers, marks all keys released, drops the
//   held key and restores the delays to 500 and 175 ms.
// A stalled result holds; the input register still fills, and scan_stall
//   rises only while both registers are occupied and the result is stalled.
module key_click_autorepeat import kca_pkg::*; #(
  parameter int                 KEY_COUNT          = DEF_KEY_COUNT,
  parameter logic [DELAY_W-1:0] FIRST_DELAY_RESET  = DEF_FIRST_DELAY,
  parameter logic [DELAY_W-1:0] REPEAT_DELAY_RESET = DEF_REPEAT_DELAY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   scan_valid,
  output logic                   scan_stall,
  input  scan_item_t             scan,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_item_t           result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]     cfg_data
);

  scan_item_t   item;
  logic         item_valid;
  logic         advance;
  logic         accept;
  kca_keys_t    keys;
  result_item_t res;

  assign cfg_ready  = 1'b1;
  assign advance    = item_valid && (!result_valid || !result_stall);
  assign scan_stall = item_valid && !advance;
  assign accept     = scan_valid && !scan_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  kca_decode #(
    .KEY_COUNT(KEY_COUNT)
  ) u_decode (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .update(advance),
    .keys  (keys)
  );

  kca_typematic #(
    .KEY_COUNT         (KEY_COUNT),
    .FIRST_DELAY_RESET (FIRST_DELAY_RESET),
    .REPEAT_DELAY_RESET(REPEAT_DELAY_RESET)
  ) u_typematic (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item),
    .keys     (keys),
    .update   (advance),
    .res      (res)
  );

endmodule

// ===== design/kca_checker.sv =====
`timescale 1ns / 1ps
`include "key_click_autorepeat_defines.svh"
module kca_checker import kca_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   scan_valid,
  input logic                   scan_stall,
  input scan_item_t             scan,
  input logic                   result_valid,
  input logic                   result_stall,
  input result_item_t           result,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [DELAY_W-1:0]     cfg_data
);

  `KCA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result item changed")
  `KCA_ASSERT_ALWAYS(a_reset_empty, rst, !result_valid && !scan_stall, "pipeline not empty after reset")
  `KCA_ASSERT_NOW(a_stall_cause, scan_stall, result_valid && result_stall, "scan stalled with result side free")
  `KCA_ASSERT_NOW(a_click_event, result_valid && result.clicked_key != '0, result.auto_key == result.clicked_key && !result.auto_is_repeat && result.pressed_key != '0 && result.pressed_key <= result.clicked_key, "click not reported as event")

endmodule

bind key_click_autorepeat kca_checker u_kca_checker (.*);
